/* hw/rtl/dcgc_pkg.sv */
// Shared types, codes and reset values for the dual countdown game clock.
// No dependencies; every other file of the block but dcgc_if imports this package.
package dcgc_pkg;

  // Game phase held by the core.
  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_RUN  = 2'd1,
    PH_OVER = 2'd2
  } phase_t;

  // Button codes carried in a button word.
  localparam logic [1:0] BTN_WHITE = 2'd0;
  localparam logic [1:0] BTN_BLACK = 2'd1;
  localparam logic [1:0] BTN_PAUSE = 2'd2;
  localparam logic [1:0] BTN_RESET = 2'd3;

  // Command codes.
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_BUTTON = 1'b1;

  // Warning levels.
  localparam logic [1:0] WARN_NONE = 2'd0;
  localparam logic [1:0] WARN_LOW  = 2'd1;
  localparam logic [1:0] WARN_CRIT = 2'd2;

  // Configuration register indexes (byte address is four times the index).
  localparam logic [1:0] REG_INITIAL   = 2'd0;
  localparam logic [1:0] REG_INCREMENT = 2'd1;
  localparam logic [1:0] REG_TPS       = 2'd2;
  localparam logic [1:0] REG_DEBOUNCE  = 2'd3;

  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;

  // Configuration reset values.
  localparam logic [15:0] RST_INITIAL   = 16'd60;
  localparam logic [7:0]  RST_INCREMENT = 8'd0;
  localparam logic [15:0] RST_TPS       = 16'd1000;
  localparam logic [15:0] RST_DEBOUNCE  = 16'd200;

  typedef struct packed {
    logic [15:0] initial_seconds;
    logic [7:0]  increment_seconds;
    logic [15:0] ticks_per_second;
    logic [15:0] debounce_ticks;
  } cfg_t;

  typedef struct packed {
    logic [15:0] white_left;
    logic [15:0] black_left;
    logic        black_to_move;
    logic        is_paused;
    logic [1:0]  play_phase;
    logic [1:0]  warn_level;
    logic        button_taken;
    logic        time_out;
  } res_t;

endpackage

/* hw/rtl/dcgc_if.sv */
// Valid/ready channel interfaces for the game clock's input and result words.
// Depends on nothing; the top level instantiates neither, it takes them as ports.
interface dcgc_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [1:0] button;

  modport source (output valid, output command, output button, input ready);
  modport sink   (input valid, input command, input button, output ready);
endinterface

interface dcgc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] white_left;
  logic [15:0] black_left;
  logic        black_to_move;
  logic        is_paused;
  logic [1:0]  play_phase;
  logic [1:0]  warn_level;
  logic        button_taken;
  logic        time_out;

  modport source (output valid, output white_left, output black_left,
                  output black_to_move, output is_paused, output play_phase,
                  output warn_level, output button_taken, output time_out,
                  input ready);
  modport sink   (input valid, input white_left, input black_left,
                  input black_to_move, input is_paused, input play_phase,
                  input warn_level, input button_taken, input time_out,
                  output ready);
endinterface

/* hw/rtl/dcgc_cfg.sv */
// APB-style configuration register bank of the game clock.
// Depends on dcgc_pkg for the register indexes, reset values and cfg_t.
module dcgc_cfg import dcgc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = paddr[3:2];
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.initial_seconds   <= RST_INITIAL;
      cfg_r.increment_seconds <= RST_INCREMENT;
      cfg_r.ticks_per_second  <= RST_TPS;
      cfg_r.debounce_ticks    <= RST_DEBOUNCE;
    end else if (wr_en) begin
      unique case (idx)
        REG_INITIAL:   cfg_r.initial_seconds   <= pwdata[15:0];
        REG_INCREMENT: cfg_r.increment_seconds <= pwdata[7:0];
        REG_TPS:       cfg_r.ticks_per_second  <= pwdata[15:0];
        REG_DEBOUNCE:  cfg_r.debounce_ticks    <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_INITIAL:   prdata = {16'd0, cfg_r.initial_seconds};
      REG_INCREMENT: prdata = {24'd0, cfg_r.increment_seconds};
      REG_TPS:       prdata = {16'd0, cfg_r.ticks_per_second};
      REG_DEBOUNCE:  prdata = {16'd0, cfg_r.debounce_ticks};
    endcase
  end

endmodule

/* hw/rtl/dcgc_core.sv */
// Game state registers and the single-pass update for one word.
// Depends on dcgc_pkg for phase_t, cfg_t, res_t and the button codes.
module dcgc_core import dcgc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       fire,
  input  logic       command,
  input  logic [1:0] button,
  output res_t       res
);

  logic [15:0] white_r, white_nxt;
  logic [15:0] black_r, black_nxt;
  logic [15:0] live_r, live_nxt;
  logic [15:0] wsave_r, wsave_nxt;
  logic [15:0] bsave_r, bsave_nxt;
  logic        bact_r, bact_nxt;
  logic        paused_r, paused_nxt;
  phase_t      phase_r, phase_nxt;
  logic [15:0] deb_r, deb_nxt;

  logic        taken;
  logic        tout;
  logic [16:0] phase_inc;
  logic [15:0] act_cnt;
  logic [15:0] act_dec;
  logic [16:0] inc_sum;
  logic [15:0] inc_sat;
  logic [15:0] warn_cnt;
  logic [19:0] cnt_x10;
  logic [19:0] cnt_x5;
  logic [1:0]  warn;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_r  <= '0;
      black_r  <= '0;
      live_r   <= '0;
      wsave_r  <= '0;
      bsave_r  <= '0;
      bact_r   <= 1'b1;
      paused_r <= 1'b0;
      phase_r  <= PH_WAIT;
      deb_r    <= '0;
    end else if (fire) begin
      white_r  <= white_nxt;
      black_r  <= black_nxt;
      live_r   <= live_nxt;
      wsave_r  <= wsave_nxt;
      bsave_r  <= bsave_nxt;
      bact_r   <= bact_nxt;
      paused_r <= paused_nxt;
      phase_r  <= phase_nxt;
      deb_r    <= deb_nxt;
    end
  end

  assign phase_inc = {1'b0, live_r} + 17'd1;
  assign act_cnt   = bact_r ? black_r : white_r;
  assign act_dec   = act_cnt - 16'd1;
  assign inc_sum   = {1'b0, act_cnt} + {9'd0, cfg.increment_seconds};
  assign inc_sat   = inc_sum[16] ? 16'hFFFF : inc_sum[15:0];

  always_comb begin
    white_nxt  = white_r;
    black_nxt  = black_r;
    live_nxt   = live_r;
    wsave_nxt  = wsave_r;
    bsave_nxt  = bsave_r;
    bact_nxt   = bact_r;
    paused_nxt = paused_r;
    phase_nxt  = phase_r;
    deb_nxt    = deb_r;
    taken      = 1'b0;
    tout       = 1'b0;

    if (command == CMD_TICK) begin
      if (deb_r != 16'd0) deb_nxt = deb_r - 16'd1;
      if (phase_r == PH_RUN) begin
        // A clock already at zero (a game started with no time) ends at once.
        if (white_r == 16'd0 || black_r == 16'd0) begin
          phase_nxt = PH_OVER;
          tout      = 1'b1;
        end else if (!paused_r) begin
          if (phase_inc >= {1'b0, cfg.ticks_per_second}) begin
            live_nxt = '0;
            if (bact_r) black_nxt = act_dec;
            else        white_nxt = act_dec;
            if (act_dec == 16'd0) begin
              phase_nxt = PH_OVER;
              tout      = 1'b1;
            end
          end else begin
            live_nxt = phase_inc[15:0];
          end
        end
      end
    end else if (deb_r == 16'd0) begin
      taken   = 1'b1;
      deb_nxt = cfg.debounce_ticks;
      unique case (phase_r)
        PH_WAIT: begin
          if (button == BTN_BLACK) begin
            white_nxt  = cfg.initial_seconds;
            black_nxt  = cfg.initial_seconds;
            live_nxt   = '0;
            wsave_nxt  = '0;
            bsave_nxt  = '0;
            bact_nxt   = 1'b0;
            paused_nxt = 1'b0;
            phase_nxt  = PH_RUN;
          end
        end
        PH_RUN: begin
          unique case (button)
            BTN_WHITE, BTN_BLACK: begin
              if (bact_r == button[0]) begin
                // The mover banks the increment and swaps sub-second phases.
                if (bact_r) begin
                  black_nxt = inc_sat;
                  bsave_nxt = live_r;
                  live_nxt  = wsave_r;
                end else begin
                  white_nxt = inc_sat;
                  wsave_nxt = live_r;
                  live_nxt  = bsave_r;
                end
                bact_nxt = ~bact_r;
              end else begin
                paused_nxt = 1'b0;
              end
            end
            BTN_PAUSE: paused_nxt = 1'b1;
            BTN_RESET: phase_nxt  = PH_WAIT;
          endcase
        end
        default: begin
          if (button == BTN_RESET) phase_nxt = PH_WAIT;
        end
      endcase
    end
  end

  // Warning compares the active clock against a tenth and a fifth of the start time.
  assign warn_cnt = bact_nxt ? black_nxt : white_nxt;
  assign cnt_x10  = {1'b0, warn_cnt, 3'd0} + {3'd0, warn_cnt, 1'b0};
  assign cnt_x5   = {2'd0, warn_cnt, 2'd0} + {4'd0, warn_cnt};

  always_comb begin
    warn = WARN_NONE;
    if (phase_nxt != PH_WAIT) begin
      priority if (cnt_x10 < {4'd0, cfg.initial_seconds}) warn = WARN_CRIT;
      else if (cnt_x5 < {4'd0, cfg.initial_seconds})      warn = WARN_LOW;
      else                                                warn = WARN_NONE;
    end
  end

  always_comb begin
    res.white_left    = white_nxt;
    res.black_left    = black_nxt;
    res.black_to_move = bact_nxt;
    res.is_paused     = paused_nxt;
    res.play_phase    = phase_nxt;
    res.warn_level    = warn;
    res.button_taken  = taken;
    res.time_out      = tout;
  end

endmodule

/* hw/rtl/dual_countdown_game_clock_unit.sv */
// Dual countdown game clock: an accepted word passes through the input register, then the update
// into the result register; throughput is one word per cycle while the result side does not stall.
// The rate is set by the single-pass state update in dcgc_core, which sits between the two.
// Reset (rst_n low, synchronous) restores the default configuration, clears both clocks,
// phases and the debounce count, sets black active and the phase to waiting, and empties
// both registers; no clearing pass is needed, so words are taken from the first cycle after.
module dual_countdown_game_clock_unit import dcgc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  dcgc_in_if.sink           in_ch,
  dcgc_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  // The input register holds one word; it is handed to the core once the result
  // register is empty or being drained in the same cycle, so a waiting result never
  // blocks intake of the next word by more than the one slot in the input register.
  logic       in_valid_r;
  logic       in_cmd_r;
  logic [1:0] in_btn_r;
  logic       out_valid_r;
  res_t       out_res_r;

  cfg_t       cfg;
  res_t       res;
  logic       advance;
  logic       fire;
  logic       in_take;

  assign pready  = 1'b1;

  assign advance = ~out_valid_r | out_ch.ready;
  assign fire    = in_valid_r & advance;
  assign in_take = ~in_valid_r | advance;

  assign in_ch.ready = in_take;

  dcgc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  dcgc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .fire    (fire),
    .command (in_cmd_r),
    .button  (in_btn_r),
    .res     (res)
  );

  // Input register: refilled whenever its word moves on or it is empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && in_ch.valid) begin
      in_cmd_r <= in_ch.command;
      in_btn_r <= in_ch.button;
    end
  end

  // Result register: loaded on the same edge at which the core commits its state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.white_left    = out_res_r.white_left;
  assign out_ch.black_left    = out_res_r.black_left;
  assign out_ch.black_to_move = out_res_r.black_to_move;
  assign out_ch.is_paused     = out_res_r.is_paused;
  assign out_ch.play_phase    = out_res_r.play_phase;
  assign out_ch.warn_level    = out_res_r.warn_level;
  assign out_ch.button_taken  = out_res_r.button_taken;
  assign out_ch.time_out      = out_res_r.time_out;

endmodule

/* tb/sv/dual_countdown_game_clock_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the dual countdown game clock unit.
// Depends on dcgc_pkg, the dcgc_in_if and dcgc_out_if interfaces and the unit itself.
module dual_countdown_game_clock_unit_tb;
  import dcgc_pkg::*;

  // Kinds of row in the opening table: a word checked against the clock model,
  // a word whose reading is written out by hand, or a register write.
  typedef enum logic [1:0] {
    ROW_WORD,
    ROW_WORD_KNOWN,
    ROW_REG
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        cmd;
    logic [1:0]  btn;
    logic [1:0]  reg_idx;
    logic [15:0] value;
    res_t        known;
  } plan_row_t;

  // Readings that can be stated at a glance.
  localparam res_t IDLE_VIEW  = '{16'd0, 16'd0, 1'b1, 1'b0, PH_WAIT, WARN_NONE, 1'b0, 1'b0};
  localparam res_t IDLE_TAKEN = '{16'd0, 16'd0, 1'b1, 1'b0, PH_WAIT, WARN_NONE, 1'b1, 1'b0};
  localparam res_t ZERO_START = '{16'd0, 16'd0, 1'b0, 1'b0, PH_RUN, WARN_NONE, 1'b1, 1'b0};
  localparam res_t ZERO_FLAG  = '{16'd0, 16'd0, 1'b0, 1'b1, PH_OVER, WARN_NONE, 1'b0, 1'b1};
  localparam res_t NO_VIEW    = '0;

  // The opening sequence. It first looks at the unit straight out of reset, with
  // the debounce window cut to one tick, so that the second button is swallowed
  // and a single tick then clears the window. It then plays a game started
  // with no time at all, which must flag on the very next tick although paused,
  // and ignore ticks once it is over. A game at the largest initial time follows,
  // with the largest increment saturating the clocks, zero ticks per second making
  // every tick a whole second, a move while paused and a resume by the opponent.
  // The last game lowers ticks per second below the live phase and runs a
  // clock out.
  plan_row_t opening_plan [36] = '{
    '{ROW_WORD_KNOWN, CMD_TICK,   BTN_WHITE, REG_INITIAL,   16'd0,     IDLE_VIEW},
    '{ROW_REG,        CMD_TICK,   BTN_WHITE, REG_DEBOUNCE,  16'd1,     NO_VIEW},
    '{ROW_WORD_KNOWN, CMD_BUTTON, BTN_WHITE, REG_INITIAL,   16'd0,     IDLE_TAKEN},
    '{ROW_WORD_KNOWN, CMD_BUTTON, BTN_BLACK, REG_INITIAL,   16'd0,     IDLE_VIEW},
    '{ROW_WORD_KNOWN, CMD_TICK,   BTN_WHITE, REG_INITIAL,   16'd0,     IDLE_VIEW},
    '{ROW_REG,        CMD_TICK,   BTN_WHITE, REG_DEBOUNCE,  16'd0,     NO_VIEW},
    '{ROW_REG,        CMD_TICK,   BTN_WHITE, REG_INITIAL,   16'd0,     NO_VIEW},
    '{ROW_REG,        CMD_TICK,   BTN_WHITE, REG_TPS,       16'd0,     NO_VIEW},
    '{ROW_REG,        CMD_TICK,   BTN_WHITE, REG_INCREMENT, 16'd255,   NO_VIEW},
    '{ROW_WORD_KNOWN, CMD_BUTTON, BTN_BLACK, REG_INITIAL,   16'd0,     ZERO_START},
    '{ROW_WORD,       CMD_BUTTON, BTN_PAUSE, REG_INITIAL,   16'd0,     NO_VIEW},
    '{ROW_WORD_KNOWN, CMD_TICK,   BTN_RESET, REG_INITIAL,   16'd0,     ZERO_FLAG},
    '{ROW_WORD,       CMD_TICK,   BTN_PAUSE, REG_INITIAL,   16'd0,     NO_VIEW},
    '{ROW_WORD,       CMD_BUTTON, BTN_WHITE, REG_INITIAL,   16'd0,     NO_VIEW},
    '{ROW_WORD,       CMD_BUTTON, BTN_RESET, REG_INITIAL,   16'd0,     NO_VIEW},
    '{ROW_REG,        CMD_TICK,   BTN_WHITE, REG_INITIAL,   16'hFFFF,  NO_VIEW},
    '{ROW_WORD,       CMD_BUTTON, BTN_BLACK, REG_INITIAL,   16'd0,     NO_VIEW},
    '{ROW_WORD,       CMD_BUTTON, BTN_WHITE, REG_INITIAL,   16'd0,     NO_VIEW},
    '{ROW_WORD,       CMD_TICK,   BTN_BLACK, REG_INITIAL,   16'd0,     NO_VIEW},
    '{ROW_WORD,       CMD_BUTTON, BTN_WHITE, REG_INITIAL,   16'd0,     NO_VIEW},
    '{ROW_WORD,       CMD_BUTTON, BTN_PAUSE, REG_INITIAL,   16'd0,     NO_VIEW},
    '{ROW_WORD,       CMD_TICK,   BTN_WHITE, REG_INITIAL,   16'd0,     NO_VIEW},
    '{ROW_WORD,       CMD_BUTTON, BTN_BLACK, REG_INITIAL,   16'd0,     NO_VIEW},
    '{ROW_WORD,       CMD_BUTTON, BTN_BLACK, REG_INITIAL,   16'd0,     NO_VIEW},
    '{ROW_WORD,       CMD_BUTTON, BTN_RESET, REG_INITIAL,   16'd0,     NO_VIEW},
    '{ROW_REG,        CMD_TICK,   BTN_WHITE, REG_INITIAL,   16'd2,     NO_VIEW},
    '{ROW_REG,        CMD_TICK,   BTN_WHITE, REG_TPS,       16'd3,     NO_VIEW},
    '{ROW_REG,        CMD_TICK,   BTN_WHITE, REG_INCREMENT, 16'd0,     NO_VIEW},
    '{ROW_REG,        CMD_TICK,   BTN_WHITE, REG_DEBOUNCE,  16'd1,     NO_VIEW},
    '{ROW_WORD,       CMD_BUTTON, BTN_BLACK, REG_INITIAL,   16'd0,     NO_VIEW},
    '{ROW_WORD,       CMD_BUTTON, BTN_WHITE, REG_INITIAL,   16'd0,     NO_VIEW},
    '{ROW_WORD,       CMD_TICK,   BTN_RESET, REG_INITIAL,   16'd0,     NO_VIEW},
    '{ROW_WORD,       CMD_TICK,   BTN_WHITE, REG_INITIAL,   16'd0,     NO_VIEW},
    '{ROW_REG,        CMD_TICK,   BTN_WHITE, REG_TPS,       16'd1,     NO_VIEW},
    '{ROW_WORD,       CMD_TICK,   BTN_BLACK, REG_INITIAL,   16'd0,     NO_VIEW},
    '{ROW_WORD,       CMD_TICK,   BTN_PAUSE, REG_INITIAL,   16'd0,     NO_VIEW}
  };

  logic clk = 1'b0;
  logic rst_n;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  dcgc_in_if  in_ch ();
  dcgc_out_if out_ch ();

  dual_countdown_game_clock_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // The testbench's own copy of the clock settings and game state.
  cfg_t        clock_cfg;
  logic [15:0] white_secs;
  logic [15:0] black_secs;
  logic [15:0] sub_phase;
  logic [15:0] white_saved;
  logic [15:0] black_saved;
  logic        black_turn;
  logic        on_hold;
  phase_t      stage;
  logic [15:0] bounce_left;

  res_t pending_readings [$];
  res_t seen_word;
  res_t due_word;
  int   mismatch_count = 0;

  // Idling is switched off for stretches of the run, and for good near the end.
  logic steady  = 1'b0;
  logic closing = 1'b0;

  function automatic logic [15:0] plus_increment(input logic [15:0] secs);
    int unsigned sum;
    sum = secs + clock_cfg.increment_seconds;
    return (sum > 32'hFFFF) ? 16'hFFFF : 16'(sum);
  endfunction

  // Applies one word to the game state and returns the reading the unit should
  // show afterwards.
  function automatic res_t advance_clock(input logic cmd, input logic [1:0] btn);
    res_t        r;
    int unsigned nxt;
    int unsigned active_left;
    r = '0;
    if (cmd == CMD_TICK) begin
      // Ticks always run the debounce window down, whatever the phase.
      if (bounce_left != 0) bounce_left--;
      if (stage == PH_RUN) begin
        if (white_secs == 0 || black_secs == 0) begin
          // A game started with no time flags on its first tick, even paused.
          stage = PH_OVER;
          r.time_out = 1'b1;
        end else if (!on_hold) begin
          // A zero tick rate, or a live phase left above a lowered rate, makes
          // this tick complete the second.
          nxt = sub_phase + 1;
          if (nxt >= clock_cfg.ticks_per_second) begin
            sub_phase = '0;
            if (black_turn) black_secs--;
            else white_secs--;
            if ((black_turn ? black_secs : white_secs) == 0) begin
              stage = PH_OVER;
              r.time_out = 1'b1;
            end
          end else begin
            sub_phase = 16'(nxt);
          end
        end
      end
    end else if (bounce_left == 0) begin
      r.button_taken = 1'b1;
      bounce_left = clock_cfg.debounce_ticks;
      case (stage)
        PH_WAIT: begin
          if (btn == BTN_BLACK) begin
            white_secs  = clock_cfg.initial_seconds;
            black_secs  = clock_cfg.initial_seconds;
            sub_phase   = '0;
            white_saved = '0;
            black_saved = '0;
            black_turn  = 1'b0;
            on_hold     = 1'b0;
            stage       = PH_RUN;
          end
        end
        PH_RUN: begin
          if (btn == BTN_WHITE || btn == BTN_BLACK) begin
            if (black_turn == btn[0]) begin
              // A move: the mover gains the increment and the phases swap over.
              if (black_turn) begin
                black_secs  = plus_increment(black_secs);
                black_saved = sub_phase;
                sub_phase   = white_saved;
                black_turn  = 1'b0;
              end else begin
                white_secs  = plus_increment(white_secs);
                white_saved = sub_phase;
                sub_phase   = black_saved;
                black_turn  = 1'b1;
              end
            end else if (on_hold) begin
              on_hold = 1'b0;
            end
          end else if (btn == BTN_PAUSE) begin
            on_hold = 1'b1;
          end else begin
            stage = PH_WAIT;
          end
        end
        default: begin
          if (btn == BTN_RESET) stage = PH_WAIT;
        end
      endcase
    end

    if (stage != PH_WAIT) begin
      active_left = black_turn ? black_secs : white_secs;
      if (10 * active_left < clock_cfg.initial_seconds) r.warn_level = WARN_CRIT;
      else if (5 * active_left < clock_cfg.initial_seconds) r.warn_level = WARN_LOW;
      else r.warn_level = WARN_NONE;
    end
    r.white_left    = white_secs;
    r.black_left    = black_secs;
    r.black_to_move = black_turn;
    r.is_paused     = on_hold;
    r.play_phase    = stage;
    return r;
  endfunction

  // Offers one word, with an occasional gap before it, and records the reading
  // it should produce once the unit has taken it. Starts at a falling edge and
  // returns at the rising edge that accepted the word.
  task automatic send_word(input logic cmd, input logic [1:0] btn, input logic use_known,
                           input res_t known);
    res_t predicted;
    @(negedge clk);
    if (!steady && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.button  <= btn;
    do @(posedge clk); while (!in_ch.ready);
    predicted = advance_clock(cmd, btn);
    pending_readings.push_back(use_known ? known : predicted);
  endtask

  // Writes one register once the unit has delivered every reading still owed,
  // with the input held idle.
  task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({idx, 2'b00});
    pwdata  <= CFG_DW'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_INITIAL:   clock_cfg.initial_seconds   = value;
      REG_INCREMENT: clock_cfg.increment_seconds = value[7:0];
      REG_TPS:       clock_cfg.ticks_per_second  = value;
      default:       clock_cfg.debounce_ticks    = value;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // The result side stalls in bursts, except while idling is switched off.
  initial begin : result_ready_driver
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!steady && stall_left == 0 && $urandom_range(0, 9) == 0)
        stall_left = $urandom_range(1, 12);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0 && !steady) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = 0;
      end
    end
  end

  // Every reading the unit hands over is matched against the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_word = '{out_ch.white_left, out_ch.black_left, out_ch.black_to_move,
                    out_ch.is_paused, out_ch.play_phase, out_ch.warn_level,
                    out_ch.button_taken, out_ch.time_out};
      if (pending_readings.size() == 0) begin
        mismatch_count++;
        $display("%0t: reading with none owed: w=%0d b=%0d btm=%0b pause=%0b ph=%0d",
                 $time, seen_word.white_left, seen_word.black_left,
                 seen_word.black_to_move, seen_word.is_paused, seen_word.play_phase);
      end else begin
        due_word = pending_readings.pop_front();
        if (seen_word !== due_word) begin
          mismatch_count++;
          $display("%0t: reading mismatch", $time);
          $display("  expected w=%0d b=%0d btm=%0b pause=%0b ph=%0d warn=%0d taken=%0b to=%0b",
                   due_word.white_left, due_word.black_left, due_word.black_to_move,
                   due_word.is_paused, due_word.play_phase, due_word.warn_level,
                   due_word.button_taken, due_word.time_out);
          $display("  actual   w=%0d b=%0d btm=%0b pause=%0b ph=%0d warn=%0d taken=%0b to=%0b",
                   seen_word.white_left, seen_word.black_left, seen_word.black_to_move,
                   seen_word.is_paused, seen_word.play_phase, seen_word.warn_level,
                   seen_word.button_taken, seen_word.time_out);
        end
      end
    end
  end

  // Guard against a hung handshake: the slowest correct run is far shorter.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int          round;
    int          n;
    int          r;
    logic        cmd;
    logic [1:0]  btn;
    logic [15:0] init_secs;
    logic [15:0] incr_secs;
    logic [15:0] tick_rate;
    logic [15:0] bounce;

    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_TICK;
    in_ch.button  = BTN_WHITE;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;

    clock_cfg   = '{RST_INITIAL, RST_INCREMENT, RST_TPS, RST_DEBOUNCE};
    white_secs  = '0;
    black_secs  = '0;
    sub_phase   = '0;
    white_saved = '0;
    black_saved = '0;
    black_turn  = 1'b1;
    on_hold     = 1'b0;
    stage       = PH_WAIT;
    bounce_left = '0;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    foreach (opening_plan[i]) begin
      if (opening_plan[i].kind == ROW_REG)
        write_register(opening_plan[i].reg_idx, opening_plan[i].value);
      else
        send_word(opening_plan[i].cmd, opening_plan[i].btn,
                  opening_plan[i].kind == ROW_WORD_KNOWN, opening_plan[i].known);
    end

    // Random games, each round under fresh settings. Small clocks and tick rates
    // keep games short, so they start, warn, flag and restart many times over.
    for (round = 0; round < 8; round++) begin
      case ($urandom_range(0, 9))
        0:       init_secs = 16'd0;
        1:       init_secs = 16'hFFFF;
        2:       init_secs = 16'($urandom_range(20, 300));
        default: init_secs = 16'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 9))
        0:       incr_secs = 16'd255;
        1, 2:    incr_secs = 16'd0;
        default: incr_secs = 16'($urandom_range(1, 3));
      endcase
      case ($urandom_range(0, 9))
        0:       tick_rate = 16'hFFFF;
        1:       tick_rate = 16'd0;
        default: tick_rate = 16'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 9))
        0:          bounce = 16'($urandom_range(20, 60));
        1, 2, 3:    bounce = 16'd0;
        default:    bounce = 16'($urandom_range(1, 4));
      endcase
      // Make sure the top of the tick rate and of the debounce window are seen.
      // The longest window outlives any round, so it only comes in the last one.
      if (round == 2) tick_rate = 16'hFFFF;
      if (round == 7) bounce = 16'hFFFF;
      write_register(REG_INITIAL, init_secs);
      write_register(REG_INCREMENT, incr_secs);
      write_register(REG_TPS, tick_rate);
      write_register(REG_DEBOUNCE, bounce);

      closing = (round == 7);
      for (n = 0; n < 230; n++) begin
        if (n % 40 == 0) steady = closing || ($urandom_range(0, 3) == 0);
        // Mostly sensible play for the current phase, with some noise on top.
        r   = $urandom_range(0, 99);
        cmd = CMD_BUTTON;
        btn = 2'($urandom_range(0, 3));
        case (stage)
          PH_WAIT: begin
            if (r < 35) cmd = CMD_TICK;
            else if (r < 80) btn = BTN_BLACK;
          end
          PH_RUN: begin
            if (r < 55) cmd = CMD_TICK;
            else if (r < 78) btn = black_turn ? BTN_BLACK : BTN_WHITE;
            else if (r < 85) btn = black_turn ? BTN_WHITE : BTN_BLACK;
            else if (r < 90) btn = BTN_PAUSE;
            else if (r < 93) btn = BTN_RESET;
          end
          default: begin
            if (r < 45) cmd = CMD_TICK;
            else if (r < 75) btn = BTN_RESET;
          end
        endcase
        send_word(cmd, btn, 1'b0, NO_VIEW);
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
